[rtl/fcce_pkg.sv]
package fcce_pkg;

   localparam int CMD_W    = 2;
   localparam int ENTRY_W  = 16;
   localparam int COUNT_W  = 12;
   localparam int STATUS_W = 2;

   localparam logic [ENTRY_W-1:0] CHAIN_END_MIN = 16'hFFF8;
   localparam logic [ENTRY_W-1:0] CHAIN_LAST    = 16'hFFFF;
   localparam logic [ENTRY_W-1:0] FREE_ENTRY    = 16'h0000;
   localparam logic [ENTRY_W-1:0] FIRST_DATA    = 16'd2;
   localparam logic [COUNT_W-1:0] TOTAL_RESET   = 12'd4094;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_FREE  = 2'd2,
      CMD_ALLOC = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_NOSPACE = 2'd1,
      ST_OUTSIDE = 2'd2,
      ST_LOOP    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_FREE_CHK,
      S_FREE_RD,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_LINK_RD,
      S_LINK_CHK,
      S_LINK_END,
      S_DONE
   } state_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [ENTRY_W-1:0]   cluster;
      logic [ENTRY_W-1:0]   entry_value;
      logic [COUNT_W-1:0]   cluster_count;
   } req_type;

   typedef struct packed {
      logic [ENTRY_W-1:0]   result_value;
      logic [COUNT_W-1:0]   clusters_done;
      status_type           status;
   } rsp_type;

endpackage

[rtl/fcce_ram.sv]
module fcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/fcce_engine.sv]
module fcce_engine
   import fcce_pkg::*;
#(
   parameter int FAT_ENTRIES = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  req_type             req,
   input  logic [COUNT_W-1:0]  total_clusters,
   output logic                ready,
   output logic                res_valid,
   input  logic                res_ready,
   output rsp_type             res
);

   localparam int AW = $clog2(FAT_ENTRIES);
   localparam logic [AW-1:0] LAST_ENTRY = AW'(FAT_ENTRIES - 1);

   state_type            state_ff, state_in;
   logic [ENTRY_W-1:0]   cur_ff, cur_in;
   logic [AW-1:0]        scan_ff, scan_in;
   logic [AW-1:0]        prev_ff, prev_in;
   logic                 have_prev_ff, have_prev_in;
   logic [AW-1:0]        last_ff, last_in;
   logic [COUNT_W-1:0]   found_ff, found_in;
   logic [COUNT_W-1:0]   want_ff, want_in;
   rsp_type              res_ff, res_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [ENTRY_W-1:0]   wr_data;
   logic [AW-1:0]        rd_addr;
   logic [ENTRY_W-1:0]   rd_data;

   logic [16:0]          lim;
   logic                 req_outside;
   logic                 cur_link;
   logic                 cur_outside;
   logic                 hit;
   logic [COUNT_W-1:0]   found_inc;

   fcce_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (FAT_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
      end
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      have_prev_ff <= have_prev_in;
      last_ff      <= last_in;
      found_ff     <= found_in;
      want_ff      <= want_in;
      res_ff       <= res_in;
   end

   assign lim         = 17'(total_clusters) + 17'd1;
   assign req_outside = {1'b0, req.cluster} >= 17'(FAT_ENTRIES);
   assign cur_link    = (cur_ff >= FIRST_DATA) && (cur_ff < CHAIN_END_MIN);
   assign cur_outside = {1'b0, cur_ff} >= 17'(FAT_ENTRIES);
   assign hit         = rd_data == FREE_ENTRY;
   assign found_inc   = found_ff + COUNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      scan_in      = scan_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      last_in      = last_ff;
      found_in     = found_ff;
      want_in      = want_ff;
      res_in       = res_ff;
      wr_en        = 1'b0;
      wr_addr      = scan_ff;
      wr_data      = FREE_ENTRY;
      rd_addr      = scan_ff;
      ready        = 1'b0;
      res_valid    = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            scan_in = scan_ff + AW'(1);
            if (scan_ff == LAST_ENTRY) begin
               scan_in  = '0;
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            ready   = 1'b1;
            rd_addr = req.cluster[AW-1:0];
            if (start) begin
               res_in   = '{result_value: '0, clusters_done: '0, status: ST_OK};
               cur_in   = req.cluster;
               found_in = '0;
               want_in  = req.cluster_count;
               last_in  = (lim > 17'(LAST_ENTRY)) ? LAST_ENTRY : lim[AW-1:0];
               scan_in  = FIRST_DATA[AW-1:0];
               unique case (req.cmd)
                  CMD_READ: begin
                     if (req_outside) begin
                        res_in.status = ST_OUTSIDE;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  CMD_WRITE: begin
                     if (req_outside) begin
                        res_in.status = ST_OUTSIDE;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = req.cluster[AW-1:0];
                        wr_data = req.entry_value;
                     end
                     state_in = S_DONE;
                  end
                  CMD_FREE: begin
                     state_in = S_FREE_CHK;
                  end
                  CMD_ALLOC: begin
                     if (req.cluster_count == '0) begin
                        state_in = S_DONE;
                     end else if (lim < 17'(FIRST_DATA)) begin
                        res_in.status = ST_NOSPACE;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         S_READ: begin
            res_in.result_value = rd_data;
            state_in            = S_DONE;
         end

         S_FREE_CHK: begin
            rd_addr = cur_ff[AW-1:0];
            if (!cur_link) begin
               res_in.clusters_done = found_ff;
               state_in             = S_DONE;
            end else if (cur_outside) begin
               res_in.clusters_done = found_ff;
               res_in.status        = ST_OUTSIDE;
               state_in             = S_DONE;
            end else if (found_ff >= total_clusters) begin
               res_in.clusters_done = found_ff;
               res_in.status        = ST_LOOP;
               state_in             = S_DONE;
            end else begin
               state_in = S_FREE_RD;
            end
         end

         S_FREE_RD: begin
            wr_en    = 1'b1;
            wr_addr  = cur_ff[AW-1:0];
            wr_data  = FREE_ENTRY;
            found_in = found_inc;
            cur_in   = rd_data;
            state_in = S_FREE_CHK;
         end

         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end

         S_SCAN_CHK: begin
            if (hit && found_inc == want_ff) begin
               scan_in      = FIRST_DATA[AW-1:0];
               found_in     = '0;
               have_prev_in = 1'b0;
               state_in     = S_LINK_RD;
            end else if (scan_ff == last_ff) begin
               res_in.status = ST_NOSPACE;
               state_in      = S_DONE;
            end else begin
               if (hit) begin
                  found_in = found_inc;
               end
               scan_in  = scan_ff + AW'(1);
               state_in = S_SCAN_RD;
            end
         end

         S_LINK_RD: begin
            state_in = S_LINK_CHK;
         end

         S_LINK_CHK: begin
            state_in = S_LINK_RD;
            scan_in  = scan_ff + AW'(1);
            if (hit) begin
               if (have_prev_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = prev_ff;
                  wr_data = ENTRY_W'(scan_ff);
               end else begin
                  res_in.result_value = ENTRY_W'(scan_ff);
               end
               prev_in      = scan_ff;
               have_prev_in = 1'b1;
               found_in     = found_inc;
               if (found_inc == want_ff) begin
                  scan_in  = scan_ff;
                  state_in = S_LINK_END;
               end
            end
         end

         S_LINK_END: begin
            wr_en                = 1'b1;
            wr_addr              = prev_ff;
            wr_data              = CHAIN_LAST;
            res_in.clusters_done = want_ff;
            state_in             = S_DONE;
         end

         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign res = res_ff;

endmodule

[rtl/fat16_cluster_chain_engine.sv]
// FAT16 allocation-table engine: one item on req_ is one command and gives exactly one item
// on rsp_. After reset the table is swept to zero, entry by entry, with req_tready low.
// All work goes through one table RAM with one write and one registered read port; a read
// passes through S_READ, free chain reads, checks and frees entry by entry, and allocate
// chain reads and checks each entry scanned in each of its two passes (count, then link),
// then writes the chain end. One command is worked at a time; a finished result waits in
// the output register while the next command is taken. total_clusters may be written
// through csr_ only while idle.
module fat16_cluster_chain_engine
   import fcce_pkg::*;
#(
   parameter int FAT_ENTRIES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd[1:0], cluster[17:2], entry_value[33:18], cluster_count[45:34]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_value[15:0], clusters_done[27:16], status[29:28]
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [11:0] csr_data
);

   logic [COUNT_W-1:0] total_ff;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   rsp_type            rsp_ff, rsp_in;
   req_type            req;
   rsp_type            res;
   logic               start;
   logic               eng_ready;
   logic               res_valid;
   logic               res_ready;

   assign req.cmd           = cmd_type'(req_tdata[1:0]);
   assign req.cluster       = req_tdata[17:2];
   assign req.entry_value   = req_tdata[33:18];
   assign req.cluster_count = req_tdata[45:34];

   assign req_tready = eng_ready;
   assign start      = req_tvalid && eng_ready;
   assign res_ready  = !rsp_tvalid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   fcce_engine #(
      .FAT_ENTRIES (FAT_ENTRIES)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req            (req),
      .total_clusters (total_ff),
      .ready          (eng_ready),
      .res_valid      (res_valid),
      .res_ready      (res_ready),
      .res            (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= TOTAL_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            total_ff <= csr_data;
         end
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_ff <= rsp_in;
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_in        = rsp_ff;
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_tvalid_in = 1'b1;
         rsp_in        = res;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.status, rsp_ff.clusters_done, rsp_ff.result_value};

   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared while the engine was idle");

   a_engine_holds: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_ready |=> res_valid && $stable(res))
      else $error("engine dropped a result waiting for the output register");

   a_nospace_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.status == ST_NOSPACE |->
         rsp_ff.result_value == '0 && rsp_ff.clusters_done == '0)
      else $error("no-space result carries data");

endmodule

[tb/tb_fat16_cluster_chain_engine.sv]
module tb_fat16_cluster_chain_engine;
   import fcce_pkg::*;

   localparam int FAT_ENTRIES = 4096;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int HOLD_CYCLES = 300;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [11:0] csr_data   = '0;

   class fat_scoreboard;
      logic [ENTRY_W-1:0] fat_copy [FAT_ENTRIES];
      int unsigned        span;
      rsp_type            awaited[$];
      int                 errors;
      int                 checked;
      int                 cmd_seen [4];
      int                 status_seen [4];

      function new();
         foreach (fat_copy[i]) fat_copy[i] = FREE_ENTRY;
         span    = TOTAL_RESET;
         errors  = 0;
         checked = 0;
      endfunction

      function void set_span(logic [COUNT_W-1:0] v);
         span = v;
      endfunction

      function rsp_type free_chain(int unsigned start);
         rsp_type     o;
         int unsigned c;
         int unsigned n;
         int unsigned nxt;
         o.result_value = '0;
         o.status       = ST_OK;
         c = start;
         n = 0;
         while (c >= FIRST_DATA && c < CHAIN_END_MIN) begin
            if (c >= FAT_ENTRIES) begin
               o.status = ST_OUTSIDE;
               break;
            end
            if (n >= span) begin
               o.status = ST_LOOP;
               break;
            end
            nxt = fat_copy[c];
            fat_copy[c] = FREE_ENTRY;
            n++;
            c = nxt;
         end
         o.clusters_done = COUNT_W'(n);
         return o;
      endfunction

      function rsp_type alloc_chain(int unsigned want);
         rsp_type     o;
         int unsigned last;
         int unsigned c;
         int unsigned found;
         int unsigned prev;
         bit          linked;
         o.result_value  = '0;
         o.clusters_done = '0;
         o.status        = ST_OK;
         last = span + 1;
         if (last >= FAT_ENTRIES) last = FAT_ENTRIES - 1;
         found = 0;
         for (c = FIRST_DATA; c <= last && found < want; c++)
            if (fat_copy[c] == FREE_ENTRY) found++;
         if (found < want) begin
            o.status = ST_NOSPACE;
            return o;
         end
         if (want == 0) return o;
         found  = 0;
         linked = 1'b0;
         prev   = 0;
         for (c = FIRST_DATA; c <= last && found < want; c++) begin
            if (fat_copy[c] != FREE_ENTRY) continue;
            if (linked) fat_copy[prev] = ENTRY_W'(c);
            else o.result_value = ENTRY_W'(c);
            prev   = c;
            linked = 1'b1;
            found++;
         end
         fat_copy[prev]  = CHAIN_LAST;
         o.clusters_done = COUNT_W'(want);
         return o;
      endfunction

      function rsp_type note_request(req_type r);
         rsp_type o;
         o.result_value  = '0;
         o.clusters_done = '0;
         o.status        = ST_OK;
         case (r.cmd)
            CMD_READ, CMD_WRITE: begin
               if (r.cluster >= FAT_ENTRIES) o.status = ST_OUTSIDE;
               else if (r.cmd == CMD_READ) o.result_value = fat_copy[r.cluster];
               else fat_copy[r.cluster] = r.entry_value;
            end
            CMD_FREE: o = free_chain(r.cluster);
            default:  o = alloc_chain(r.cluster_count);
         endcase
         cmd_seen[r.cmd]++;
         status_seen[o.status]++;
         awaited.push_back(o);
         return o;
      endfunction

      task report(string what, int got, int want);
         errors++;
         $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      endtask

      task check_response(logic [31:0] data);
         rsp_type e;
         if (awaited.size() == 0) begin
            report("result with nothing outstanding", data, 0);
            return;
         end
         e = awaited.pop_front();
         checked++;
         if (data[15:0] !== e.result_value)
            report("result_value", data[15:0], e.result_value);
         if (data[27:16] !== e.clusters_done)
            report("clusters_done", data[27:16], e.clusters_done);
         if (data[29:28] !== e.status)
            report("status", data[29:28], e.status);
      endtask
   endclass

   fat_scoreboard sb;
   int unsigned   cycles = 0;
   int unsigned   heads[$];
   int            burst_left = 0;
   bit            gaps_on = 1'b0;
   bit            hold_wanted = 1'b0;
   int            held = 0;
   int            stall_mode = 0;
   int            mode_left = 0;
   int            settings_used = 0;

   fat16_cluster_chain_engine #(
      .FAT_ENTRIES(FAT_ENTRIES)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) sb.check_response(rsp_tdata);
   end

   // hold off once for a long stretch, otherwise stall on a changing pattern
   always @(negedge clock) begin
      if (hold_wanted && held < HOLD_CYCLES) begin
         held       <= held + 1;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= (mode_left % 4 == 0);
            default: rsp_tready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   function req_type cmd_item(cmd_type c, int unsigned cl, int unsigned val, int unsigned cnt);
      req_type r;
      r.cmd           = c;
      r.cluster       = ENTRY_W'(cl);
      r.entry_value   = ENTRY_W'(val);
      r.cluster_count = COUNT_W'(cnt);
      return r;
   endfunction

   function req_type random_req(int unsigned span, bit wide);
      req_type     r;
      int unsigned reach;
      int unsigned pick;
      int unsigned k;
      int unsigned idx;
      reach = (span + 4 > FAT_ENTRIES - 1) ? FAT_ENTRIES - 1 : span + 4;
      r = cmd_item(CMD_READ, $urandom, $urandom, $urandom_range(0, 4094));
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, 99);
      if (pick < 30) begin
         r.cmd = CMD_ALLOC;
         if (k < 60) r.cluster_count = COUNT_W'($urandom_range(0, 6));
         else if (k < 90) r.cluster_count = wide ? COUNT_W'($urandom_range(0, 300))
                                                 : COUNT_W'($urandom_range(0, span + 2));
         else r.cluster_count = wide ? COUNT_W'($urandom_range(0, 64))
                                     : COUNT_W'($urandom_range(0, 4094));
      end else if (pick < 55) begin
         r.cmd = CMD_FREE;
         if (heads.size() > 0 && k < 60) begin
            idx       = $urandom_range(0, heads.size() - 1);
            r.cluster = ENTRY_W'(heads[idx]);
            heads.delete(idx);
         end else if (k < 90) begin
            r.cluster = ENTRY_W'($urandom_range(0, reach));
         end
      end else if (pick < 80) begin
         r.cmd = CMD_READ;
         if (k < 85) r.cluster = ENTRY_W'($urandom_range(0, reach));
      end else begin
         r.cmd = CMD_WRITE;
         if (k < 90) r.cluster = ENTRY_W'($urandom_range(0, reach));
         pick = $urandom_range(0, 99);
         if (pick < 30) r.entry_value = ENTRY_W'($urandom_range(FIRST_DATA, reach));
         else if (pick < 50) r.entry_value = FREE_ENTRY;
         else if (pick < 70)
            r.entry_value = ENTRY_W'($urandom_range(CHAIN_END_MIN, CHAIN_LAST));
      end
      return r;
   endfunction

   task send_req(req_type r);
      rsp_type e;
      req_tdata  <= {2'b00, r.cluster_count, r.entry_value, r.cluster, r.cmd};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      e = sb.note_request(r);
      if (r.cmd == CMD_ALLOC && e.status == ST_OK && e.clusters_done != 0)
         heads.push_back(e.result_value);
      @(negedge clock);
      if (gaps_on) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            burst_left = $urandom_range(0, 15);
         end
      end
   endtask

   task drain();
      req_tvalid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task set_span(int unsigned v);
      drain();
      csr_data  <= COUNT_W'(v);
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_span(COUNT_W'(v));
      settings_used++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task run_phase(int unsigned span, int n, bit gaps, int hold_at, int pause_at);
      set_span(span);
      gaps_on    = gaps;
      burst_left = $urandom_range(0, 15);
      for (int i = 0; i < n; i++) begin
         if (i == hold_at) hold_wanted <= 1'b1;
         if (i == pause_at) drain();
         send_req(random_req(span, span > 1000));
      end
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_req(cmd_item(CMD_ALLOC, 0, 0, 4094));
      send_req(cmd_item(CMD_READ, 2, 0, 0));
      send_req(cmd_item(CMD_READ, 4095, 0, 0));
      send_req(cmd_item(CMD_ALLOC, 0, 0, 1));
      send_req(cmd_item(CMD_FREE, 2, 0, 0));
      send_req(cmd_item(CMD_READ, 16'hFFFF, 0, 0));
      send_req(cmd_item(CMD_WRITE, 4096, 16'h1234, 0));
      send_req(cmd_item(CMD_READ, 4095, 0, 0));
      send_req(cmd_item(CMD_ALLOC, 0, 0, 0));
      send_req(cmd_item(CMD_WRITE, 3, 5, 0));
      send_req(cmd_item(CMD_WRITE, 5, 16'hFFF7, 0));
      send_req(cmd_item(CMD_FREE, 3, 0, 0));
      send_req(cmd_item(CMD_FREE, CHAIN_END_MIN, 0, 0));
      send_req(cmd_item(CMD_FREE, 1, 0, 0));
      send_req(cmd_item(CMD_FREE, 0, 0, 0));
      send_req(cmd_item(CMD_WRITE, 10, 11, 0));
      send_req(cmd_item(CMD_WRITE, 11, 10, 0));
      send_req(cmd_item(CMD_FREE, 10, 0, 0));
      send_req(cmd_item(CMD_WRITE, 0, CHAIN_LAST, 0));
      send_req(cmd_item(CMD_WRITE, 1, 16'hABCD, 0));
      send_req(cmd_item(CMD_READ, 0, 0, 0));
      send_req(cmd_item(CMD_READ, 1, 0, 0));
      set_span(1);
      send_req(cmd_item(CMD_WRITE, 20, 21, 0));
      send_req(cmd_item(CMD_WRITE, 21, CHAIN_LAST, 0));
      send_req(cmd_item(CMD_FREE, 20, 0, 0));
      set_span(0);
      send_req(cmd_item(CMD_ALLOC, 0, 0, 1));
      send_req(cmd_item(CMD_FREE, 21, 0, 0));

      run_phase(4094, 15, 1'b1, -1, -1);
      run_phase(7, 80, 1'b1, -1, -1);
      run_phase(23, 90, 1'b0, 30, -1);
      run_phase(64, 90, 1'b1, -1, 45);
      run_phase(3, 60, 1'b1, -1, -1);
      run_phase(130, 90, 1'b0, -1, -1);
      run_phase(37, 90, 1'b1, -1, -1);
      run_phase(2, 40, 1'b1, -1, -1);

      drain();
      repeat (40) @(posedge clock);

      $display("Ran %0d commands (%0d read, %0d write, %0d free, %0d allocate), %0d settings",
               sb.checked, sb.cmd_seen[CMD_READ], sb.cmd_seen[CMD_WRITE],
               sb.cmd_seen[CMD_FREE], sb.cmd_seen[CMD_ALLOC], settings_used);
      $display("Outcomes: %0d ok, %0d no space, %0d outside table, %0d too long; %0d mismatches",
               sb.status_seen[ST_OK], sb.status_seen[ST_NOSPACE],
               sb.status_seen[ST_OUTSIDE], sb.status_seen[ST_LOOP], sb.errors);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
